FILE: rtl/awfe_pkg.sv
`default_nettype none

package awfe_pkg;

   // Fixed field widths of the sample and result items.
   localparam int SAMPLE_BITS  = 10;
   localparam int LABEL_W      = 8;
   localparam int MEAN_W       = 18;
   localparam int VAR_W        = 27;
   localparam int COUNT_OUT_W  = 13;

   // Configuration port.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_ADDR_W-1:0] CSR_CLASS_LABEL    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOW_THRESHOLD  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HIGH_THRESHOLD = 2'd2;

   localparam logic [LABEL_W-1:0]     LABEL_RESET     = 8'd0;
   localparam logic [SAMPLE_BITS-1:0] LOW_THR_RESET   = 10'd522;
   localparam logic [SAMPLE_BITS-1:0] HIGH_THR_RESET  = 10'd532;

   // One input item.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_value;
      logic                   window_end;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [LABEL_W-1:0]     label;
      logic [MEAN_W-1:0]      mean_q8;
      logic [VAR_W-1:0]       variance_q8;
      logic [SAMPLE_BITS-1:0] peak_value;
      logic [COUNT_OUT_W-1:0] crossings;
      logic [COUNT_OUT_W-1:0] samples_taken;
      logic                   single_sample;
      logic                   window_overflow;
   } rsp_type;

   // Sequencer of the back part.
   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL_A,
      BK_MUL_B,
      BK_MUL_C,
      BK_DIV_MEAN,
      BK_WAIT_MEAN,
      BK_DIV_VAR,
      BK_WAIT_VAR,
      BK_OUT
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/audio_window_feature_extractor.sv
`default_nettype none

// Window feature extractor for 10-bit microphone samples. The front part takes one sample
// item per cycle, keeps the exact sum, sum of squares, peak, count and hysteresis crossing
// count, and on the item that carries window_end hands the finished window to a two-entry
// queue and starts a new window in the next cycle. req_stall rises only for a closing item
// while the queue holds two windows not yet taken by the back part. The back part works one
// window at a time: products in states BK_MUL_A, BK_MUL_B and BK_MUL_C, then a restoring
// divider that produces one quotient bit per cycle, run once for the mean and once for the
// variance (a one-sample window skips the variance division); the result item is then held
// while rsp_stall is high. The divider sets the rate for windows; samples before the
// closing one are never slowed. Samples past MAX_WINDOW are ignored and flagged in the
// result.
module audio_window_feature_extractor #(
   parameter int MAX_WINDOW = 4096
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  awfe_pkg::req_type          req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output awfe_pkg::rsp_type                rsp_data,
   input  wire                              csr_we,
   input  wire  [awfe_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire  [awfe_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SB    = awfe_pkg::SAMPLE_BITS;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = SB + CNT_W;
   localparam int SQ_W  = 2 * SB + CNT_W;
   localparam int NUM_W = SQ_W + CNT_W;
   localparam int DEN_W = 2 * CNT_W;
   localparam int DIV_W = NUM_W + 8;
   localparam int REC_W = awfe_pkg::LABEL_W + SUM_W + SQ_W + SB + 2 * CNT_W + 1;

   logic             q_full;
   logic             q_empty;
   logic             q_push;
   logic             q_pop;
   logic [REC_W-1:0] q_push_rec;
   logic [REC_W-1:0] q_pop_rec;

   logic             div_start;
   logic             div_done;
   logic [DIV_W-1:0] div_dividend;
   logic [DEN_W-1:0] div_divisor;
   logic [DIV_W-1:0] div_quotient;

   // Front part: sample accumulation and configuration registers.
   awfe_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .CNT_W      (CNT_W),
      .SUM_W      (SUM_W),
      .SQ_W       (SQ_W),
      .REC_W      (REC_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_rec     (q_push_rec)
   );

   // Finished windows waiting for the back part.
   awfe_queue #(
      .WIDTH (REC_W),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_rec),
      .pop       (q_pop),
      .pop_data  (q_pop_rec),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Shared bit-serial divider for mean and variance.
   awfe_divider #(
      .DIV_W (DIV_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Back part: products, divisions and the result item.
   awfe_back #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W),
      .SQ_W  (SQ_W),
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .DIV_W (DIV_W),
      .REC_W (REC_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_rec        (q_pop_rec),
      .q_pop        (q_pop),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/awfe_front.sv
`default_nettype none

module awfe_front #(
   parameter int MAX_WINDOW = 4096,
   parameter int CNT_W      = 13,
   parameter int SUM_W      = 23,
   parameter int SQ_W       = 33,
   parameter int REC_W      = 100
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  awfe_pkg::req_type             req_data,
   input  wire                                 csr_we,
   input  wire  [awfe_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire  [awfe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire                                 q_full,
   output logic                                q_push,
   output logic [REC_W-1:0]                    q_rec
);

   logic [awfe_pkg::LABEL_W-1:0]     label_ff;
   logic [awfe_pkg::SAMPLE_BITS-1:0] low_thr_ff;
   logic [awfe_pkg::SAMPLE_BITS-1:0] high_thr_ff;

   logic [SUM_W-1:0]                 sum_ff, sum_in;
   logic [SQ_W-1:0]                  sq_ff, sq_in;
   logic [awfe_pkg::SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [CNT_W-1:0]                 cross_ff, cross_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic                             below_ff, below_in;
   logic                             ovf_ff, ovf_in;

   logic                             accept;
   logic                             full;
   logic [awfe_pkg::SAMPLE_BITS-1:0] v;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         label_ff    <= awfe_pkg::LABEL_RESET;
         low_thr_ff  <= awfe_pkg::LOW_THR_RESET;
         high_thr_ff <= awfe_pkg::HIGH_THR_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            awfe_pkg::CSR_CLASS_LABEL:    label_ff    <= csr_wdata[awfe_pkg::LABEL_W-1:0];
            awfe_pkg::CSR_LOW_THRESHOLD:  low_thr_ff  <= csr_wdata;
            awfe_pkg::CSR_HIGH_THRESHOLD: high_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A closing item waits only when the queue has no room.
   assign req_stall = q_full && req_data.window_end;
   assign accept    = req_valid && !req_stall;
   assign v         = req_data.sample_value;
   assign full      = (count_ff == CNT_W'(MAX_WINDOW));

   // Window accumulation for one item; a full window ignores the sample.
   always_comb begin
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      peak_in  = peak_ff;
      cross_in = cross_ff;
      count_in = count_ff;
      below_in = below_ff;
      ovf_in   = ovf_ff;
      if (full) begin
         ovf_in = 1'b1;
      end else begin
         count_in = count_ff + CNT_W'(1);
         sum_in   = sum_ff + SUM_W'(v);
         sq_in    = sq_ff + SQ_W'(v) * SQ_W'(v);
         if (v > peak_ff) begin
            peak_in = v;
         end
         if (!below_ff && (v < low_thr_ff)) begin
            cross_in = cross_ff + CNT_W'(1);
            below_in = 1'b1;
         end else if (below_ff && (v > high_thr_ff)) begin
            cross_in = cross_ff + CNT_W'(1);
            below_in = 1'b0;
         end
      end
   end

   // The closing item hands the finished window to the queue.
   assign q_push = accept && req_data.window_end;
   assign q_rec  = {label_ff, sum_in, sq_in, peak_in, cross_in, count_in, ovf_in};

   // Window state, cleared after each closing item.
   always_ff @(posedge clock) begin
      if (reset || q_push) begin
         sum_ff   <= '0;
         sq_ff    <= '0;
         peak_ff  <= '0;
         cross_ff <= '0;
         count_ff <= '0;
         below_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         peak_ff  <= peak_in;
         cross_ff <= cross_in;
         count_ff <= count_in;
         below_ff <= below_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/awfe_queue.sv
`default_nettype none

module awfe_queue #(
   parameter int WIDTH = 100,
   parameter int DEPTH = 2
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire  [WIDTH-1:0]  push_data,
   input  wire               pop,
   output logic [WIDTH-1:0]  pop_data,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/awfe_divider.sv
`default_nettype none

module awfe_divider #(
   parameter int DIV_W = 53,
   parameter int DEN_W = 26
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire  [DIV_W-1:0]  dividend,
   input  wire  [DEN_W-1:0]  divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic              done_ff;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              take;

   // One restoring step: bring down the next dividend bit and try the subtract.
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign take  = (trial >= {1'b0, den_ff});

   assign done     = done_ff;
   assign quotient = quo_ff;

   // Control: step count and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            step_ff <= STEP_W'(DIV_W);
         end else if (step_ff != '0) begin
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: remainder and the shift register that turns dividend into quotient.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= divisor;
         quo_ff <= dividend;
      end else if (step_ff != '0) begin
         rem_ff <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], take};
      end
   end

endmodule

`default_nettype wire

FILE: rtl/awfe_back.sv
`default_nettype none

module awfe_back #(
   parameter int CNT_W = 13,
   parameter int SUM_W = 23,
   parameter int SQ_W  = 33,
   parameter int NUM_W = 46,
   parameter int DEN_W = 26,
   parameter int DIV_W = 54,
   parameter int REC_W = 100
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     q_empty,
   input  wire  [REC_W-1:0]        q_rec,
   output logic                    q_pop,
   output logic                    div_start,
   output logic [DIV_W-1:0]        div_dividend,
   output logic [DEN_W-1:0]        div_divisor,
   input  wire                     div_done,
   input  wire  [DIV_W-1:0]        div_quotient,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output awfe_pkg::rsp_type       rsp_data
);

   localparam int MEAN_W = awfe_pkg::MEAN_W;
   localparam int VAR_W  = awfe_pkg::VAR_W;
   localparam int COUT_W = awfe_pkg::COUNT_OUT_W;

   awfe_pkg::back_state_type state_ff, state_in;

   logic [awfe_pkg::LABEL_W-1:0]     r_label;
   logic [SUM_W-1:0]                 r_sum;
   logic [SQ_W-1:0]                  r_sq;
   logic [awfe_pkg::SAMPLE_BITS-1:0] r_peak;
   logic [CNT_W-1:0]                 r_cross;
   logic [CNT_W-1:0]                 r_count;
   logic                             r_ovf;

   logic [awfe_pkg::LABEL_W-1:0]     label_ff;
   logic [SUM_W-1:0]                 sum_ff;
   logic [SQ_W-1:0]                  sq_ff;
   logic [awfe_pkg::SAMPLE_BITS-1:0] peak_ff;
   logic [CNT_W-1:0]                 cross_ff;
   logic [CNT_W-1:0]                 n_ff;
   logic                             ovf_ff;
   logic [NUM_W-1:0]                 prod_ff;
   logic [NUM_W-1:0]                 sqr_ff;
   logic [NUM_W-1:0]                 num_ff;
   logic [DEN_W-1:0]                 den_ff;
   logic [MEAN_W-1:0]                mean_ff;
   logic [VAR_W-1:0]                 var_ff;

   logic                             n_zero;
   logic                             n_small;
   logic [DIV_W+MEAN_W-1:0]          quo_wide;
   logic [MEAN_W-1:0]                mean_sat;
   logic [VAR_W-1:0]                 var_sat;
   logic [CNT_W+COUT_W-1:0]          n_wide;
   logic [CNT_W+COUT_W-1:0]          cross_wide;

   assign {r_label, r_sum, r_sq, r_peak, r_cross, r_count, r_ovf} = q_rec;

   assign n_zero  = (n_ff == '0);
   assign n_small = (n_ff <= CNT_W'(1));

   // Saturate the quotient to the mean and variance field widths.
   assign quo_wide = (DIV_W + MEAN_W)'(div_quotient);
   assign mean_sat = (quo_wide > (DIV_W + MEAN_W)'({MEAN_W{1'b1}})) ?
                     {MEAN_W{1'b1}} : quo_wide[MEAN_W-1:0];
   assign var_sat  = (quo_wide > (DIV_W + MEAN_W)'({VAR_W{1'b1}})) ?
                     {VAR_W{1'b1}} : quo_wide[VAR_W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         awfe_pkg::BK_IDLE:      if (!q_empty) state_in = awfe_pkg::BK_MUL_A;
         awfe_pkg::BK_MUL_A:     state_in = awfe_pkg::BK_MUL_B;
         awfe_pkg::BK_MUL_B:     state_in = awfe_pkg::BK_MUL_C;
         awfe_pkg::BK_MUL_C:     state_in = awfe_pkg::BK_DIV_MEAN;
         awfe_pkg::BK_DIV_MEAN:  state_in = n_zero ? awfe_pkg::BK_DIV_VAR
                                                   : awfe_pkg::BK_WAIT_MEAN;
         awfe_pkg::BK_WAIT_MEAN: if (div_done) state_in = awfe_pkg::BK_DIV_VAR;
         awfe_pkg::BK_DIV_VAR:   state_in = n_small ? awfe_pkg::BK_OUT
                                                    : awfe_pkg::BK_WAIT_VAR;
         awfe_pkg::BK_WAIT_VAR:  if (div_done) state_in = awfe_pkg::BK_OUT;
         awfe_pkg::BK_OUT:       if (!rsp_stall) state_in = awfe_pkg::BK_IDLE;
         default:                state_in = awfe_pkg::BK_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      q_pop        = 1'b0;
      div_start    = 1'b0;
      rsp_valid    = 1'b0;
      div_dividend = DIV_W'({num_ff, 8'd0});
      div_divisor  = den_ff;
      case (state_ff)
         awfe_pkg::BK_IDLE: begin
            q_pop = !q_empty;
         end
         awfe_pkg::BK_DIV_MEAN: begin
            div_start    = !n_zero;
            div_dividend = DIV_W'({sum_ff, 8'd0});
            div_divisor  = DEN_W'(n_ff);
         end
         awfe_pkg::BK_DIV_VAR: begin
            div_start = !n_small;
         end
         awfe_pkg::BK_OUT: begin
            rsp_valid = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= awfe_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Window record, products and results.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         label_ff <= r_label;
         sum_ff   <= r_sum;
         sq_ff    <= r_sq;
         peak_ff  <= r_peak;
         cross_ff <= r_cross;
         n_ff     <= r_count;
         ovf_ff   <= r_ovf;
      end
      if (state_ff == awfe_pkg::BK_MUL_A) begin
         prod_ff <= NUM_W'(n_ff) * NUM_W'(sq_ff);
      end
      if (state_ff == awfe_pkg::BK_MUL_B) begin
         sqr_ff <= NUM_W'(sum_ff) * NUM_W'(sum_ff);
      end
      if (state_ff == awfe_pkg::BK_MUL_C) begin
         num_ff <= prod_ff - sqr_ff;
         den_ff <= DEN_W'(n_ff) * DEN_W'(n_ff - CNT_W'(1));
      end
      if ((state_ff == awfe_pkg::BK_DIV_MEAN) && n_zero) begin
         mean_ff <= '0;
      end else if ((state_ff == awfe_pkg::BK_WAIT_MEAN) && div_done) begin
         mean_ff <= mean_sat;
      end
      if ((state_ff == awfe_pkg::BK_DIV_VAR) && n_small) begin
         var_ff <= '0;
      end else if ((state_ff == awfe_pkg::BK_WAIT_VAR) && div_done) begin
         var_ff <= var_sat;
      end
   end

   // Result item, held steady while the sequencer waits in its output state.
   assign n_wide     = (CNT_W + COUT_W)'(n_ff);
   assign cross_wide = (CNT_W + COUT_W)'(cross_ff);

   always_comb begin
      rsp_data.label           = label_ff;
      rsp_data.mean_q8         = mean_ff;
      rsp_data.variance_q8     = var_ff;
      rsp_data.peak_value      = peak_ff;
      rsp_data.crossings       = (cross_wide > (CNT_W + COUT_W)'({COUT_W{1'b1}})) ?
                                 {COUT_W{1'b1}} : cross_wide[COUT_W-1:0];
      rsp_data.samples_taken   = (n_wide > (CNT_W + COUT_W)'({COUT_W{1'b1}})) ?
                                 {COUT_W{1'b1}} : n_wide[COUT_W-1:0];
      rsp_data.single_sample   = (n_ff == CNT_W'(1));
      rsp_data.window_overflow = ovf_ff;
   end

endmodule

`default_nettype wire

FILE: tb/awfe_checker.sv
`default_nettype none

// Watches the sample and result channels of the window feature extractor, keeps its own
// copy of the window state and the configuration registers, works out the features of
// every closed window and compares each result item with the oldest pending one.
module awfe_window_checker #(
   parameter int MAX_WINDOW = 4096
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire                              req_stall,
   input  wire  awfe_pkg::req_type          req_data,
   input  wire                              rsp_valid,
   input  wire                              rsp_stall,
   input  wire  awfe_pkg::rsp_type          rsp_data,
   input  wire                              csr_we,
   input  wire  [awfe_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire  [awfe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               fail_count,
   output int                               features_due
);

   localparam int LABEL_W     = awfe_pkg::LABEL_W;
   localparam int SAMPLE_BITS = awfe_pkg::SAMPLE_BITS;
   localparam int MEAN_W      = awfe_pkg::MEAN_W;
   localparam int VAR_W       = awfe_pkg::VAR_W;
   localparam int COUNT_OUT_W = awfe_pkg::COUNT_OUT_W;

   // Configuration copy.
   logic [LABEL_W-1:0]     cfg_label;
   logic [SAMPLE_BITS-1:0] cfg_low;
   logic [SAMPLE_BITS-1:0] cfg_high;

   // Running window state, held wide so that no sum can wrap.
   longint unsigned        win_sum;
   longint unsigned        win_squares;
   logic [SAMPLE_BITS-1:0] win_peak;
   longint unsigned        win_crossings;
   longint unsigned        win_taken;
   logic                   win_below;
   logic                   win_overflow;

   awfe_pkg::rsp_type feature_queue[$];
   int                failures = 0;

   // Limits a value to the largest one that a field of the given width holds.
   function automatic longint unsigned clip(input longint unsigned value,
                                            input int unsigned width);
      longint unsigned top;
      top = (64'd1 << width) - 64'd1;
      return (value > top) ? top : value;
   endfunction

   task automatic clear_window();
      win_sum       = 0;
      win_squares   = 0;
      win_peak      = '0;
      win_crossings = 0;
      win_taken     = 0;
      win_below     = 1'b0;
      win_overflow  = 1'b0;
   endtask

   // Takes one sample item into the window; a closing item queues the window's features.
   task automatic absorb_sample(input awfe_pkg::req_type item);
      longint unsigned   value;
      longint unsigned   n;
      longint unsigned   num;
      longint unsigned   den;
      longint unsigned   quot;
      longint unsigned   rem;
      longint unsigned   mean;
      longint unsigned   spread;
      longint unsigned   spread_top;
      awfe_pkg::rsp_type feat;
      value = item.sample_value;
      if (win_taken < MAX_WINDOW) begin
         win_taken++;
         win_sum     += value;
         win_squares += value * value;
         if (item.sample_value > win_peak) begin
            win_peak = item.sample_value;
         end
         // Hysteresis: each state only leaves through its own threshold.
         if (!win_below && item.sample_value < cfg_low) begin
            win_crossings++;
            win_below = 1'b1;
         end else if (win_below && item.sample_value > cfg_high) begin
            win_crossings++;
            win_below = 1'b0;
         end
      end else begin
         win_overflow = 1'b1;
      end

      if (item.window_end) begin
         n          = win_taken;
         mean       = 0;
         spread     = 0;
         spread_top = (64'd1 << VAR_W) - 64'd1;
         if (n > 0) begin
            mean = (win_sum * 256) / n;
         end
         // Sample variance in Q.8, from the integer quotient and the remainder.
         if (n > 1) begin
            num  = n * win_squares - win_sum * win_sum;
            den  = n * (n - 1);
            quot = num / den;
            rem  = num % den;
            if (quot > (spread_top >> 8)) begin
               spread = spread_top;
            end else begin
               spread = clip((quot << 8) + (rem * 256) / den, VAR_W);
            end
         end
         feat.label           = cfg_label;
         feat.mean_q8         = MEAN_W'(clip(mean, MEAN_W));
         feat.variance_q8     = VAR_W'(spread);
         feat.peak_value      = win_peak;
         feat.crossings       = COUNT_OUT_W'(clip(win_crossings, COUNT_OUT_W));
         feat.samples_taken   = COUNT_OUT_W'(clip(n, COUNT_OUT_W));
         feat.single_sample   = (n == 1);
         feat.window_overflow = win_overflow;
         feature_queue.push_back(feat);
         clear_window();
      end
   endtask

   task automatic report_failure(input string msg);
      $display("%0t checker: %s", $time, msg);
      failures++;
   endtask

   task automatic check_field(input string name, input logic [63:0] seen,
                              input logic [63:0] want);
      if (seen !== want) begin
         report_failure($sformatf("%s is 0x%0h, expected 0x%0h", name, seen, want));
      end
   endtask

   // Compares one result item with the oldest pending window features.
   task automatic check_result(input awfe_pkg::rsp_type seen);
      awfe_pkg::rsp_type want;
      if (feature_queue.size() == 0) begin
         report_failure($sformatf("result item 0x%0h with no window pending", seen));
      end else begin
         want = feature_queue.pop_front();
         check_field("label", seen.label, want.label);
         check_field("mean_q8", seen.mean_q8, want.mean_q8);
         check_field("variance_q8", seen.variance_q8, want.variance_q8);
         check_field("peak_value", seen.peak_value, want.peak_value);
         check_field("crossings", seen.crossings, want.crossings);
         check_field("samples_taken", seen.samples_taken, want.samples_taken);
         check_field("single_sample", seen.single_sample, want.single_sample);
         check_field("window_overflow", seen.window_overflow, want.window_overflow);
      end
   endtask

   // Results are matched before new samples so that a window never meets its own result.
   always @(posedge clock) begin
      if (reset) begin
         cfg_label = awfe_pkg::LABEL_RESET;
         cfg_low   = awfe_pkg::LOW_THR_RESET;
         cfg_high  = awfe_pkg::HIGH_THR_RESET;
         clear_window();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
         end
         if (req_valid && !req_stall) begin
            absorb_sample(req_data);
         end
         if (csr_we) begin
            case (csr_addr)
               awfe_pkg::CSR_CLASS_LABEL: begin
                  cfg_label = csr_wdata[LABEL_W-1:0];
               end
               awfe_pkg::CSR_LOW_THRESHOLD: begin
                  cfg_low = csr_wdata[SAMPLE_BITS-1:0];
               end
               awfe_pkg::CSR_HIGH_THRESHOLD: begin
                  cfg_high = csr_wdata[SAMPLE_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      features_due <= feature_queue.size();
      fail_count   <= failures;
   end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

// Drives windows of samples into the feature extractor under several threshold and label
// settings, with bursty input and a patterned result stall; the checker beside the block
// predicts and compares every result item.
module testbench;

   localparam int SAMPLE_BITS    = awfe_pkg::SAMPLE_BITS;
   localparam int WINDOW_LIMIT   = 4096;
   localparam int SETTLE_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT = 4000;

   // Register index that maps to no register.
   localparam logic [awfe_pkg::CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {WIN_UNIFORM, WIN_THRESHOLD, WIN_EXTREME, WIN_SWING} window_style_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   awfe_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   awfe_pkg::rsp_type               rsp_data;
   logic                            csr_we    = 1'b0;
   logic [awfe_pkg::CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [awfe_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int                     fail_count;
   int                     features_due;
   int                     idle_cycles = 0;
   int                     burst_left  = 0;
   int                     stall_left  = 0;
   stall_mode_type         stall_mode  = STALL_NONE;
   logic [SAMPLE_BITS-1:0] cur_low     = awfe_pkg::LOW_THR_RESET;
   logic [SAMPLE_BITS-1:0] cur_high    = awfe_pkg::HIGH_THR_RESET;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   audio_window_feature_extractor #(
      .MAX_WINDOW (WINDOW_LIMIT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   awfe_window_checker #(
      .MAX_WINDOW (WINDOW_LIMIT)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .features_due (features_due)
   );

   // Result stall: a random mode is held for a stretch, from no stall at all to mostly stalled.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 128);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_HEAVY: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= ~rsp_stall;
         end
      endcase
   end

   // Ends the run when no item and no register write has gone through for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("testbench: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one sample item and holds it until it is taken; bursts are split by short gaps.
   task automatic send_item(input int value, input bit last);
      awfe_pkg::req_type item;
      int                gap;
      item.sample_value = SAMPLE_BITS'(value);
      item.window_end   = last;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic int pick_sample(input window_style_type style, input int idx);
      int value;
      case (style)
         WIN_THRESHOLD: begin
            value = ($urandom_range(0, 1) == 1) ? int'(cur_low) : int'(cur_high);
            value = value + int'($urandom_range(0, 6)) - 3;
            value = (value < 0) ? 0 : ((value > 1023) ? 1023 : value);
         end
         WIN_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       value = 0;
               1:       value = 1;
               2:       value = 1022;
               default: value = 1023;
            endcase
         end
         WIN_SWING: begin
            value = (idx % 2 == 0) ? $urandom_range(0, 100) : $urandom_range(923, 1023);
         end
         default: begin
            value = $urandom_range(0, 1023);
         end
      endcase
      return value;
   endfunction

   task automatic send_window(input int len, input window_style_type style);
      for (int idx = 0; idx < len; idx++) begin
         send_item(pick_sample(style, idx), idx == len - 1);
      end
   endtask

   // Holds the input idle until every pending window result has come back.
   task automatic wait_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (features_due != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [awfe_pkg::CSR_ADDR_W-1:0] addr,
                                 input logic [awfe_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == awfe_pkg::CSR_LOW_THRESHOLD) begin
         cur_low = data;
      end else if (addr == awfe_pkg::CSR_HIGH_THRESHOLD) begin
         cur_high = data;
      end
   endtask

   // Registers change only once the block has gone quiet.
   task automatic set_config(input logic [awfe_pkg::CSR_DATA_W-1:0] label,
                             input logic [awfe_pkg::CSR_DATA_W-1:0] low,
                             input logic [awfe_pkg::CSR_DATA_W-1:0] high);
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(awfe_pkg::CSR_CLASS_LABEL, label);
      write_register(awfe_pkg::CSR_LOW_THRESHOLD, low);
      write_register(awfe_pkg::CSR_HIGH_THRESHOLD, high);
   endtask

   // Random windows, mostly short; now and then the input waits for all results.
   task automatic run_windows(input int items);
      int count;
      int len;
      count = 0;
      while (count < items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         send_window(len, window_style_type'($urandom_range(0, 3)));
         count += len;
         if ($urandom_range(0, 24) == 0) begin
            wait_results();
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A write to the unused index must leave every register alone.
      write_register(CSR_SPARE, 10'($urandom_range(0, 1023)));

      // Directed windows under the reset thresholds.
      send_item(1023, 1'b1);
      send_item(0, 1'b1);
      send_item(1023, 1'b0);
      send_item(0, 1'b0);
      send_item(1023, 1'b0);
      send_item(0, 1'b0);
      send_item(512, 1'b1);
      // Samples equal to a threshold do not cross it.
      send_item(522, 1'b0);
      send_item(532, 1'b0);
      send_item(521, 1'b0);
      send_item(532, 1'b0);
      send_item(533, 1'b0);
      send_item(522, 1'b1);
      send_item(700, 1'b0);
      send_item(700, 1'b1);

      // The label register keeps only its low bits.
      set_config(10'h3AB, 10'd0, 10'd1023);
      run_windows(85);
      set_config(10'd0, 10'd1023, 10'd0);
      run_windows(85);
      set_config(10'd255, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      run_windows(85);
      set_config(10'($urandom_range(0, 1023)), 10'($urandom_range(400, 520)),
                 10'($urandom_range(530, 650)));
      run_windows(85);
      set_config(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                 10'($urandom_range(0, 1023)));
      run_windows(85);

      // A long swinging window, then a short one.
      set_config(10'($urandom_range(0, 255)), 10'd300, 10'd700);
      send_window(60, WIN_SWING);
      send_window(3, WIN_UNIFORM);

      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && features_due == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
